[design/pvt_table_interpolator_macros.svh]
`ifndef PVT_TABLE_INTERPOLATOR_MACROS_SVH
`define PVT_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define PTI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pvt_table_interpolator: assertion failed");

// next-cycle implication
`define PTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pvt_table_interpolator: assertion failed");

`endif

[design/pti_pkg.sv]
package pti_pkg;

  localparam int unsigned P_W             = 32;
  localparam int unsigned P_FRAC          = 8;
  localparam int unsigned ROW_W           = 6;
  localparam int unsigned CFG_W           = 7;
  localparam int unsigned NCOL            = 4;
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_WRITE_BAD,
    KIND_QUERY
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SWAIT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_MUL,
    ST_DLS,
    ST_DS,
    ST_DLV,
    ST_DV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic mul_bit;
    logic div_load;
    logic div_slope;
    logic div_step;
    logic cap_slope;
    logic cap_value;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

endpackage

[design/pti_front.sv]
module pti_front #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [((pti_pkg::ROW_W + pti_pkg::P_W + pti_pkg::NCOL * VALUE_WIDTH + 7) / 8) * 8 - 1:0]
                                   s_axis_tdata,
  input  logic                     s_axis_tuser,
  input  pti_pkg::back_stat_t      stat_i,
  output logic                     q_valid_o,
  output pti_pkg::kind_e           q_kind_o,
  output logic [pti_pkg::ROW_W-1:0] q_row_o,
  output logic [pti_pkg::P_W-1:0]  q_p_o,
  output logic [pti_pkg::NCOL*VALUE_WIDTH-1:0] q_vals_o
);
  import pti_pkg::*;

  localparam int unsigned VW     = VALUE_WIDTH;
  localparam int unsigned QDEPTH = 2;

  logic [1:0]           cnt_q, cnt_d;
  logic                 wp_q, rp_q;
  kind_e                kind_q [QDEPTH];
  logic [ROW_W-1:0]     row_q  [QDEPTH];
  logic [P_W-1:0]       p_q    [QDEPTH];
  logic [NCOL*VW-1:0]   v_q    [QDEPTH];
  kind_e                kind_in;
  logic                 push;
  logic [ROW_W-1:0]     row_in;

  assign row_in        = s_axis_tdata[ROW_W-1:0];
  assign s_axis_tready = cnt_q != 2'(QDEPTH);
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_axis_tuser) begin
      kind_in = KIND_QUERY;
    end else if (32'(row_in) < TABLE_DEPTH) begin
      kind_in = KIND_WRITE;
    end else begin
      kind_in = KIND_WRITE_BAD;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !stat_i.pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && stat_i.pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= !wp_q;
      end
      if (stat_i.pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wp_q] <= kind_in;
      row_q[wp_q]  <= row_in;
      p_q[wp_q]    <= s_axis_tdata[ROW_W +: P_W];
      v_q[wp_q]    <= s_axis_tdata[ROW_W + P_W +: NCOL*VW];
    end
  end

  assign q_valid_o = cnt_q != 2'd0;
  assign q_kind_o  = kind_q[rp_q];
  assign q_row_o   = row_q[rp_q];
  assign q_p_o     = p_q[rp_q];
  assign q_vals_o  = v_q[rp_q];

endmodule

[design/pti_lane.sv]
module pti_lane #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  pti_pkg::lane_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0]  v0_i,
  input  logic [VALUE_WIDTH-1:0]  v1_i,
  input  logic [pti_pkg::P_W-1:0] dp_i,
  input  logic                    diff_neg_i,
  output logic [VALUE_WIDTH-1:0]  slope_o,
  output logic [VALUE_WIDTH-1:0]  value_o
);
  import pti_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned QW = VW + 1;
  localparam int unsigned PW = VW + 1 + P_W;
  localparam int unsigned SW = VW + 3;

  function automatic logic [VW-1:0] sat_fn(input logic [SW-1:0] x);
    logic [VW-1:0] r;
    if (!x[SW-1] && (x[SW-2:VW-1] != '0)) begin
      r = {1'b0, {(VW-1){1'b1}}};
    end else if (x[SW-1] && (x[SW-2:VW-1] != '1)) begin
      r = {1'b1, {(VW-1){1'b0}}};
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

  logic              neg_q;
  logic [VW-1:0]     base_q;
  logic [VW:0]       mag_q;
  logic [PW-1:0]     mcand_q, acc_q;
  logic              ovf_q;
  logic [P_W-1:0]    rem_q;
  logic [QW-1:0]     nlow_q;
  logic [VW-1:0]     slope_q, value_q;

  logic [VW:0]       dv, dv_mag;
  logic [PW-1:0]     num;
  logic [P_W:0]      t, tsub;
  logic              ge;
  logic [QW-1:0]     lim, qc;
  logic [SW-1:0]     qx, sq_slope, sq_val, val_full;

  always_comb begin
    dv     = {v1_i[VW-1], v1_i} - {v0_i[VW-1], v0_i};
    dv_mag = dv[VW] ? -dv : dv;
    num    = ctrl_i.div_slope ? PW'({mag_q, {P_FRAC{1'b0}}}) : acc_q;
    t      = {rem_q, nlow_q[QW-1]};
    tsub   = t - {1'b0, dp_i};
    ge     = t >= {1'b0, dp_i};
    lim    = {1'b1, {VW{1'b0}}};
    qc     = (ovf_q || (nlow_q > lim)) ? lim : nlow_q;
    qx     = {2'b00, qc};
    sq_slope = neg_q ? -qx : qx;
    sq_val   = (neg_q ^ diff_neg_i) ? -qx : qx;
    val_full = {{3{base_q[VW-1]}}, base_q} + sq_val;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      neg_q   <= dv[VW];
      base_q  <= v0_i;
      mag_q   <= dv_mag;
      mcand_q <= PW'(dv_mag);
      acc_q   <= '0;
    end else if (ctrl_i.mul) begin
      if (ctrl_i.mul_bit) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q <= {mcand_q[PW-2:0], 1'b0};
    end
    if (ctrl_i.div_load) begin
      ovf_q  <= num[PW-1:QW] >= dp_i;
      rem_q  <= num[PW-1:QW];
      nlow_q <= num[QW-1:0];
    end else if (ctrl_i.div_step) begin
      rem_q  <= ge ? tsub[P_W-1:0] : t[P_W-1:0];
      nlow_q <= {nlow_q[QW-2:0], ge};
    end
    if (ctrl_i.cap_slope) begin
      slope_q <= sat_fn(sq_slope);
    end
    if (ctrl_i.cap_value) begin
      value_q <= sat_fn(val_full);
    end
  end

  assign slope_o = slope_q;
  assign value_o = value_q;

endmodule

[design/pti_back.sv]
module pti_back #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pti_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      q_valid_i,
  input  pti_pkg::kind_e            q_kind_i,
  input  logic [pti_pkg::ROW_W-1:0] q_row_i,
  input  logic [pti_pkg::P_W-1:0]   q_p_i,
  input  logic [pti_pkg::NCOL*VALUE_WIDTH-1:0] q_vals_i,
  output pti_pkg::back_stat_t       stat_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [2*pti_pkg::NCOL*VALUE_WIDTH-1:0] m_axis_tdata,
  output logic                      m_axis_tuser
);
  import pti_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned QW = VW + 1;
  localparam int unsigned PW = VW + 1 + P_W;
  localparam int unsigned CW = $clog2(PW + 1);
  localparam int unsigned OW = 2 * NCOL * VW;

  logic [P_W-1:0]     p_mem [TABLE_DEPTH];
  logic [NCOL*VW-1:0] v_mem [TABLE_DEPTH];
  logic [P_W-1:0]     rd_p_q;
  logic [NCOL*VW-1:0] rd_v_q;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   rows_q;
  logic [NW-1:0]      n_q, n_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, i_q, i_d;
  logic [P_W-1:0]     qp_q, qp_d, p0_q, p0_d, dp_q, dp_d, dmag_q, dmag_d;
  logic [NCOL*VW-1:0] v0_q, v0_d;
  logic               dneg_q, dneg_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d, out_ok_q, out_ok_d;
  logic [OW-1:0]      out_data_q, out_data_d, lane_res;
  logic               out_load, mem_we, pop, free;
  logic [AW-1:0]      raddr, waddr;
  logic [NW:0]        msum;
  logic [NW-1:0]      ival;
  logic [P_W:0]       dp_w, diff_w, ndiff_w;
  lane_ctrl_t         ctrl;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      p_mem[waddr] <= q_p_i;
      v_mem[waddr] <= q_vals_i;
    end
    rd_p_q <= p_mem[raddr];
    rd_v_q <= v_mem[raddr];
  end

  for (genvar g = 0; g < NCOL; g++) begin : g_lane
    pti_lane #(.VALUE_WIDTH(VW)) u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .v0_i       (v0_q[g*VW +: VW]),
      .v1_i       (rd_v_q[g*VW +: VW]),
      .dp_i       (dp_q),
      .diff_neg_i (dneg_q),
      .slope_o    (lane_res[(2*g+1)*VW +: VW]),
      .value_o    (lane_res[2*g*VW +: VW])
    );
  end

  assign free  = !out_valid_q || m_axis_tready;
  assign waddr = AW'(q_row_i);
  assign msum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign ival  = (lo_q == '0) ? NW'(1) : lo_q;
  assign dp_w  = {1'b0, rd_p_q} - {1'b0, p0_q};
  assign diff_w  = {1'b0, qp_q} - {1'b0, p0_q};
  assign ndiff_w = -diff_w;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    i_d        = i_q;
    qp_d       = qp_q;
    p0_d       = p0_q;
    v0_d       = v0_q;
    dp_d       = dp_q;
    dmag_d     = dmag_q;
    dneg_d     = dneg_q;
    cnt_d      = cnt_q;
    ctrl       = '0;
    mem_we     = 1'b0;
    pop        = 1'b0;
    raddr      = '0;
    out_load   = 1'b0;
    out_ok_d   = 1'b0;
    out_data_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && free) begin
          pop = 1'b1;
          unique case (q_kind_i)
            KIND_WRITE: begin
              mem_we   = 1'b1;
              out_load = 1'b1;
              out_ok_d = 1'b1;
            end
            KIND_QUERY: begin
              qp_d    = q_p_i;
              n_d     = (32'(rows_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(rows_q);
              lo_d    = '0;
              hi_d    = n_d;
              state_d = ST_SRCH;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d   = msum[NW:1];
          raddr   = mid_d[AW-1:0];
          state_d = ST_SWAIT;
        end else begin
          i_d = ival;
          if (ival >= n_q) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_RD0;
          end
        end
      end
      ST_SWAIT: begin
        if (rd_p_q < qp_q) begin
          lo_d = mid_q + NW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_SRCH;
      end
      ST_RD0: begin
        raddr   = AW'(i_q - NW'(1));
        state_d = ST_RD1;
      end
      ST_RD1: begin
        raddr   = i_q[AW-1:0];
        p0_d    = rd_p_q;
        v0_d    = rd_v_q;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        if (dp_w[P_W] || (dp_w == '0)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          dp_d      = dp_w[P_W-1:0];
          dneg_d    = diff_w[P_W];
          dmag_d    = diff_w[P_W] ? ndiff_w[P_W-1:0] : diff_w[P_W-1:0];
          ctrl.load = 1'b1;
          cnt_d     = '0;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul     = 1'b1;
        ctrl.mul_bit = dmag_q[0];
        dmag_d       = dmag_q >> 1;
        cnt_d        = cnt_q + CW'(1);
        if (cnt_q == CW'(P_W - 1)) begin
          state_d = ST_DLS;
        end
      end
      ST_DLS: begin
        ctrl.div_load  = 1'b1;
        ctrl.div_slope = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DS;
      end
      ST_DS: begin
        ctrl.div_step = 1'b1;
        cnt_d         = cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          state_d = ST_DLV;
        end
      end
      ST_DLV: begin
        ctrl.cap_slope = 1'b1;
        ctrl.div_load  = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DV;
      end
      ST_DV: begin
        ctrl.div_step = 1'b1;
        cnt_d         = cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        ctrl.cap_value = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        out_load   = 1'b1;
        out_ok_d   = 1'b1;
        out_data_d = lane_res;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rows_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    i_q    <= i_d;
    qp_q   <= qp_d;
    p0_q   <= p0_d;
    v0_q   <= v0_d;
    dp_q   <= dp_d;
    dmag_q <= dmag_d;
    dneg_q <= dneg_d;
    cnt_q  <= cnt_d;
    if (out_load) begin
      out_ok_q   <= out_ok_d;
      out_data_q <= out_data_d;
    end
  end

  assign stat_o.busy   = state_q != ST_IDLE;
  assign stat_o.pop    = pop;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

[design/pvt_table_interpolator.sv]
// PVT table interpolator.
// Input stream (s_axis): tuser selects the request kind, 0 writes a table row,
// 1 queries at a pressure. A row write stores pressure and four columns.
// User must set rows_in_use (cfg_we_i/cfg_wdata_i) while idle; not enforced.
// Output stream (m_axis): one result per request; tuser is the ok flag,
// tdata holds value and slope for each of the four columns.
// Requests enter a two-entry queue, so up to two are taken while the
// engine is busy or the output is stalled.
// A write's result is registered into the output stage as it leaves the queue.
// A query runs a binary search of at most log2(rows_in_use)+1 steps, each
// issuing a row read in ST_SRCH and comparing it in ST_SWAIT; the product uses
// a bit-serial multiplier (32 steps) and each lane runs two restoring
// divisions of VALUE_WIDTH+1 steps each; one request is worked at a time.
// A held result blocks the next request from starting until it is taken.
// Reset empties the queue and clears rows_in_use; table contents stay
// undefined until written.
module pvt_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = pti_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = pti_pkg::DEF_VALUE_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [pti_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // row_index, pressure, row_inv_fvf, row_inv_visc, row_inv_visc_fvf, row_gor
  input  logic [((pti_pkg::ROW_W + pti_pkg::P_W + pti_pkg::NCOL * VALUE_WIDTH + 7) / 8) * 8 - 1:0]
               s_axis_tdata,
  // cmd
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_inv_fvf, slope_inv_fvf, out_inv_visc, slope_inv_visc,
  // out_inv_visc_fvf, slope_inv_visc_fvf, out_gor, slope_gor
  output logic [2*pti_pkg::NCOL*VALUE_WIDTH-1:0] m_axis_tdata,
  // ok
  output logic m_axis_tuser
);
  import pti_pkg::*;

  back_stat_t               stat;
  logic                     q_valid;
  kind_e                    q_kind;
  logic [ROW_W-1:0]         q_row;
  logic [P_W-1:0]           q_p;
  logic [NCOL*VALUE_WIDTH-1:0] q_vals;

  pti_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .stat_i        (stat),
    .q_valid_o     (q_valid),
    .q_kind_o      (q_kind),
    .q_row_o       (q_row),
    .q_p_o         (q_p),
    .q_vals_o      (q_vals)
  );

  pti_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_kind_i      (q_kind),
    .q_row_i       (q_row),
    .q_p_i         (q_p),
    .q_vals_i      (q_vals),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`include "pvt_table_interpolator_macros.svh"

  `PTI_ASSERT_IMPL(a_full_has_data, clk_i, rst_ni, !s_axis_tready, q_valid)
  `PTI_ASSERT_IMPL(a_pop_has_data, clk_i, rst_ni, stat.pop, q_valid)
  `PTI_ASSERT_IMPL(a_busy_no_result, clk_i, rst_ni, stat.busy, !m_axis_tvalid)
  `PTI_ASSERT_NEXT(a_query_starts, clk_i, rst_ni, stat.pop && (q_kind == KIND_QUERY), stat.busy)

endmodule
